// ===== src/fcgi_pkg.sv =====
// Shared types, result codes and helpers of the FastCGI record parser.
package fcgi_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_BEGIN  = 3'd1,
        PH_PARAMS = 3'd2,
        PH_STDIN  = 3'd3,
        PH_SKIP   = 3'd4,
        PH_PAD    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        PP_KLEN0 = 3'd0,
        PP_KLENX = 3'd1,
        PP_VLEN0 = 3'd2,
        PP_VLENX = 3'd3,
        PP_KEY   = 3'd4,
        PP_VAL   = 3'd5
    } t_pair_phase;

    localparam logic [2:0] KIND_KEY         = 3'd0;
    localparam logic [2:0] KIND_VALUE       = 3'd1;
    localparam logic [2:0] KIND_PAIR_END    = 3'd2;
    localparam logic [2:0] KIND_STDIN       = 3'd3;
    localparam logic [2:0] KIND_BEGIN_OK    = 3'd4;
    localparam logic [2:0] KIND_PARAMS_DONE = 3'd5;
    localparam logic [2:0] KIND_STDIN_DONE  = 3'd6;
    localparam logic [2:0] KIND_ERROR       = 3'd7;

    localparam logic [1:0] ERR_ROLE    = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_TYPE    = 2'd2;

    localparam logic [7:0] TYPE_BEGIN  = 8'd1;
    localparam logic [7:0] TYPE_PARAMS = 8'd4;
    localparam logic [7:0] TYPE_STDIN  = 8'd5;
    localparam logic [7:0] TYPE_DATA   = 8'd8;

    localparam logic [15:0] ROLE_RESPONDER = 16'd1;
    localparam logic [7:0]  LEN_FLAG       = 8'h80;
    localparam logic [7:0]  LEN_MASK       = 8'h7f;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] request_number;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_step;

    typedef struct packed {
        logic       room2;
        logic [2:0] count;
    } t_queue_status;

    function automatic t_result mk_res(input logic [2:0] kind, input logic [7:0] data,
                                       input logic [1:0] err, input logic [15:0] req);
        t_result r;
        r.kind           = kind;
        r.payload_byte   = data;
        r.request_number = req;
        r.error_code     = err;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/fcgi_if.sv =====
// Valid/ready channel interfaces for stream bytes and parser results.
interface fcgi_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface fcgi_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] request_number;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output request_number,
                    output error_code, output last, input ready);
    modport sink (input valid, input kind, input payload_byte, input request_number,
                  input error_code, input last, output ready);
endinterface

// ===== src/fcgi_parse.sv =====
// Record header, begin record, PARAMS pair and STDIN parsing state machine.
module fcgi_parse
    import fcgi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data,
    output t_step      o_step
);

    t_phase      r_phase, n_phase;
    t_pair_phase r_pair_phase, n_pair_phase;
    logic [2:0]  r_header_index, n_header_index;
    logic [7:0]  r_record_kind, n_record_kind;
    logic [15:0] r_request_id, n_request_id;
    logic [15:0] r_content_left, n_content_left;
    logic [7:0]  r_padding_left, n_padding_left;
    logic [30:0] r_len_acc, n_len_acc;
    logic [1:0]  r_len_cnt, n_len_cnt;
    logic [30:0] r_key_left, n_key_left;
    logic [30:0] r_value_left, n_value_left;
    logic [7:0]  r_role_high, n_role_high;

    logic [1:0]  e_cnt;
    t_result     e_res [2];

    always_comb begin
        n_phase        = r_phase;
        n_pair_phase   = r_pair_phase;
        n_header_index = r_header_index;
        n_record_kind  = r_record_kind;
        n_request_id   = r_request_id;
        n_content_left = r_content_left;
        n_padding_left = r_padding_left;
        n_len_acc      = r_len_acc;
        n_len_cnt      = r_len_cnt;
        n_key_left     = r_key_left;
        n_value_left   = r_value_left;
        n_role_high    = r_role_high;
        e_cnt          = 2'd0;
        e_res[0]       = '0;
        e_res[1]       = '0;

        unique case (r_phase)
            PH_BEGIN: begin
                if (r_header_index == 3'd0) begin
                    n_role_high    = i_data;
                    n_header_index = 3'd1;
                end else if (r_header_index == 3'd1) begin
                    if ({r_role_high, i_data} != ROLE_RESPONDER) begin
                        if (e_cnt != 2'd2) begin
                            e_res[e_cnt[0]] = mk_res(KIND_ERROR, 8'd0, ERR_ROLE, n_request_id);
                            e_cnt = e_cnt + 2'd1;
                        end
                        n_phase = PH_SKIP;
                    end else begin
                        n_header_index = 3'd2;
                    end
                end else begin
                    if (e_cnt != 2'd2) begin
                        e_res[e_cnt[0]] = mk_res(KIND_BEGIN_OK, {7'd0, i_data[0]}, ERR_ROLE,
                                                 n_request_id);
                        e_cnt = e_cnt + 2'd1;
                    end
                    n_phase = PH_SKIP;
                end
                n_content_left = r_content_left - 16'd1;
                if (n_content_left == 16'd0) begin
                    if (n_phase == PH_BEGIN && e_cnt != 2'd2) begin
                        e_res[e_cnt[0]] = mk_res(KIND_ERROR, 8'd0, ERR_ROLE, n_request_id);
                        e_cnt = e_cnt + 2'd1;
                    end
                    n_header_index = 3'd0;
                    n_phase = (n_padding_left != 8'd0) ? PH_PAD : PH_HEADER;
                end
            end
            PH_PARAMS: begin
                unique case (r_pair_phase)
                    PP_KLENX, PP_VLENX: begin
                        n_len_acc = {r_len_acc[22:0], i_data};
                        n_len_cnt = r_len_cnt - 2'd1;
                        if (n_len_cnt == 2'd0) begin
                            if (r_pair_phase == PP_KLENX) begin
                                n_key_left   = n_len_acc;
                                n_pair_phase = PP_VLEN0;
                            end else begin
                                n_value_left = n_len_acc;
                                if (n_key_left != 31'd0) begin
                                    n_pair_phase = PP_KEY;
                                end else if (n_value_left != 31'd0) begin
                                    n_pair_phase = PP_VAL;
                                end else begin
                                    if (e_cnt != 2'd2) begin
                                        e_res[e_cnt[0]] = mk_res(KIND_PAIR_END, 8'd0, ERR_ROLE,
                                                                 n_request_id);
                                        e_cnt = e_cnt + 2'd1;
                                    end
                                    n_pair_phase = PP_KLEN0;
                                end
                            end
                        end
                    end
                    PP_VLEN0: begin
                        if ((i_data & LEN_FLAG) != 8'd0) begin
                            n_len_acc    = {23'd0, i_data & LEN_MASK};
                            n_len_cnt    = 2'd3;
                            n_pair_phase = PP_VLENX;
                        end else begin
                            n_value_left = {23'd0, i_data};
                            if (n_key_left != 31'd0) begin
                                n_pair_phase = PP_KEY;
                            end else if (n_value_left != 31'd0) begin
                                n_pair_phase = PP_VAL;
                            end else begin
                                if (e_cnt != 2'd2) begin
                                    e_res[e_cnt[0]] = mk_res(KIND_PAIR_END, 8'd0, ERR_ROLE,
                                                             n_request_id);
                                    e_cnt = e_cnt + 2'd1;
                                end
                                n_pair_phase = PP_KLEN0;
                            end
                        end
                    end
                    PP_KEY: begin
                        if (e_cnt != 2'd2) begin
                            e_res[e_cnt[0]] = mk_res(KIND_KEY, i_data, ERR_ROLE, n_request_id);
                            e_cnt = e_cnt + 2'd1;
                        end
                        n_key_left = r_key_left - 31'd1;
                        if (n_key_left == 31'd0) begin
                            if (n_value_left != 31'd0) begin
                                n_pair_phase = PP_VAL;
                            end else begin
                                if (e_cnt != 2'd2) begin
                                    e_res[e_cnt[0]] = mk_res(KIND_PAIR_END, 8'd0, ERR_ROLE,
                                                             n_request_id);
                                    e_cnt = e_cnt + 2'd1;
                                end
                                n_pair_phase = PP_KLEN0;
                            end
                        end
                    end
                    PP_VAL: begin
                        if (e_cnt != 2'd2) begin
                            e_res[e_cnt[0]] = mk_res(KIND_VALUE, i_data, ERR_ROLE, n_request_id);
                            e_cnt = e_cnt + 2'd1;
                        end
                        n_value_left = r_value_left - 31'd1;
                        if (n_value_left == 31'd0) begin
                            if (e_cnt != 2'd2) begin
                                e_res[e_cnt[0]] = mk_res(KIND_PAIR_END, 8'd0, ERR_ROLE,
                                                         n_request_id);
                                e_cnt = e_cnt + 2'd1;
                            end
                            n_pair_phase = PP_KLEN0;
                        end
                    end
                    default: begin
                        if ((i_data & LEN_FLAG) != 8'd0) begin
                            n_len_acc    = {23'd0, i_data & LEN_MASK};
                            n_len_cnt    = 2'd3;
                            n_pair_phase = PP_KLENX;
                        end else begin
                            n_key_left   = {23'd0, i_data};
                            n_pair_phase = PP_VLEN0;
                        end
                    end
                endcase
                n_content_left = r_content_left - 16'd1;
                if (n_content_left == 16'd0) begin
                    if (n_pair_phase != PP_KLEN0 && e_cnt != 2'd2) begin
                        e_res[e_cnt[0]] = mk_res(KIND_ERROR, 8'd0, ERR_OVERRUN, n_request_id);
                        e_cnt = e_cnt + 2'd1;
                    end
                    n_pair_phase   = PP_KLEN0;
                    n_header_index = 3'd0;
                    n_phase = (n_padding_left != 8'd0) ? PH_PAD : PH_HEADER;
                end
            end
            PH_STDIN, PH_SKIP: begin
                if (r_phase == PH_STDIN && e_cnt != 2'd2) begin
                    e_res[e_cnt[0]] = mk_res(KIND_STDIN, i_data, ERR_ROLE, n_request_id);
                    e_cnt = e_cnt + 2'd1;
                end
                n_content_left = r_content_left - 16'd1;
                if (n_content_left == 16'd0) begin
                    n_header_index = 3'd0;
                    n_phase = (n_padding_left != 8'd0) ? PH_PAD : PH_HEADER;
                end
            end
            PH_PAD: begin
                n_padding_left = r_padding_left - 8'd1;
                if (n_padding_left == 8'd0) begin
                    n_phase        = PH_HEADER;
                    n_header_index = 3'd0;
                end
            end
            default: begin
                n_phase = PH_HEADER;
                unique case (r_header_index)
                    3'd1:    n_record_kind = i_data;
                    3'd2:    n_request_id[15:8] = i_data;
                    3'd3:    n_request_id[7:0] = i_data;
                    3'd4:    n_content_left[15:8] = i_data;
                    3'd5:    n_content_left[7:0] = i_data;
                    3'd6:    n_padding_left = i_data;
                    default: ;
                endcase
                if (r_header_index != 3'd7) begin
                    n_header_index = r_header_index + 3'd1;
                end else begin
                    n_header_index = 3'd0;
                    n_pair_phase   = PP_KLEN0;
                    n_len_cnt      = 2'd0;
                    n_len_acc      = 31'd0;
                    n_key_left     = 31'd0;
                    n_value_left   = 31'd0;
                    unique case (n_record_kind)
                        TYPE_BEGIN: begin
                            n_phase = PH_BEGIN;
                            if (n_content_left == 16'd0) begin
                                e_res[0] = mk_res(KIND_ERROR, 8'd0, ERR_ROLE, n_request_id);
                                e_cnt = 2'd1;
                            end
                        end
                        TYPE_PARAMS: begin
                            n_phase = PH_PARAMS;
                            if (n_content_left == 16'd0) begin
                                e_res[0] = mk_res(KIND_PARAMS_DONE, 8'd0, ERR_ROLE,
                                                  n_request_id);
                                e_cnt = 2'd1;
                            end
                        end
                        TYPE_STDIN: begin
                            n_phase = PH_STDIN;
                            if (n_content_left == 16'd0) begin
                                e_res[0] = mk_res(KIND_STDIN_DONE, 8'd0, ERR_ROLE,
                                                  n_request_id);
                                e_cnt = 2'd1;
                            end
                        end
                        TYPE_DATA: begin
                            n_phase = PH_SKIP;
                        end
                        default: begin
                            n_phase  = PH_SKIP;
                            e_res[0] = mk_res(KIND_ERROR, 8'd0, ERR_TYPE, n_request_id);
                            e_cnt    = 2'd1;
                        end
                    endcase
                    if (n_content_left == 16'd0) begin
                        n_header_index = 3'd0;
                        n_phase = (n_padding_left != 8'd0) ? PH_PAD : PH_HEADER;
                    end
                end
            end
        endcase

        if (e_cnt == 2'd1) begin
            e_res[0].last = 1'b1;
        end else if (e_cnt == 2'd2) begin
            e_res[1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_pair_phase   <= PP_KLEN0;
            r_header_index <= 3'd0;
            r_record_kind  <= 8'd0;
            r_request_id   <= 16'd0;
            r_content_left <= 16'd0;
            r_padding_left <= 8'd0;
            r_len_acc      <= 31'd0;
            r_len_cnt      <= 2'd0;
            r_key_left     <= 31'd0;
            r_value_left   <= 31'd0;
            r_role_high    <= 8'd0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_pair_phase   <= n_pair_phase;
            r_header_index <= n_header_index;
            r_record_kind  <= n_record_kind;
            r_request_id   <= n_request_id;
            r_content_left <= n_content_left;
            r_padding_left <= n_padding_left;
            r_len_acc      <= n_len_acc;
            r_len_cnt      <= n_len_cnt;
            r_key_left     <= n_key_left;
            r_value_left   <= n_value_left;
            r_role_high    <= n_role_high;
        end
    end

    assign o_step.count = e_cnt;
    assign o_step.res0  = e_res[0];
    assign o_step.res1  = e_res[1];

endmodule

// ===== src/fcgi_out_queue.sv =====
// Four-entry result queue taking up to two results per cycle and giving one.
module fcgi_out_queue
    import fcgi_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_step         i_step,
    input  logic          i_pop,
    output logic          o_valid,
    output t_result       o_head,
    output t_queue_status o_status
);

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic [1:0] push_cnt;
    logic       pop_ok;

    assign push_cnt = i_push ? i_step.count : 2'd0;
    assign pop_ok   = i_pop && (r_count != 3'd0);
    assign n_wr_ptr = r_wr_ptr + push_cnt;
    assign n_rd_ptr = r_rd_ptr + {1'b0, pop_ok};
    assign n_count  = r_count + {1'b0, push_cnt} - {2'b00, pop_ok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_step.res0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_step.res1;
        end
    end

    assign o_valid        = (r_count != 3'd0);
    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.room2 = (r_count <= 3'd2);
    assign o_status.count = r_count;

endmodule

// ===== src/fastcgi_record_params_parser.sv =====
// Top level of the FastCGI record stream and PARAMS pair parser.
//
//  channel    dir  handshake        payload
//  i_byte     in   valid / ready    stream_byte[7:0]
//  o_result   out  valid / ready    kind, payload_byte, request_number, error_code, last
//
//  One byte is taken per cycle while the queue has room for two results; each byte
//  yields at most two results, and the one-wide output port of the four-entry
//  result queue drains them one at a time.
//  Path: byte register, then parse into the queue, then the result is shown.
//  Reset is synchronous, active low; a stalled output fills the queue and drops ready.
module fastcgi_record_params_parser
    import fcgi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fcgi_byte_if.sink            i_byte,
    fcgi_result_if.source        o_result
);

    logic          r_in_vld;
    logic [7:0]    r_in_byte;
    logic          step;
    logic          accept;
    t_step         step_out;
    t_result       head;
    logic          head_vld;
    t_queue_status q_stat;

    assign step         = r_in_vld && q_stat.room2;
    assign i_byte.ready = !r_in_vld || step;
    assign accept       = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte.stream_byte;
        end
    end

    fcgi_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_data  (r_in_byte),
        .o_step  (step_out)
    );

    fcgi_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (step),
        .i_step   (step_out),
        .i_pop    (o_result.ready),
        .o_valid  (head_vld),
        .o_head   (head),
        .o_status (q_stat)
    );

    assign o_result.valid          = head_vld;
    assign o_result.kind           = head.kind;
    assign o_result.payload_byte   = head.payload_byte;
    assign o_result.request_number = head.request_number;
    assign o_result.error_code     = head.error_code;
    assign o_result.last           = head.last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= 3'd4)
        else $error("result queue count out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !q_stat.room2) |-> !i_byte.ready)
        else $error("byte taken while queue lacks room");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && step_out.count == 2'd2) |-> (!step_out.res0.last && step_out.res1.last))
        else $error("last flag misplaced on a two-result byte");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && step_out.count != 2'd0) |=> o_result.valid)
        else $error("pushed result not presented");

endmodule
